// ===== rtl/etc1pis_pkg.sv =====
// Shared types, widths, stream field offsets and decode tables for the ETC1 pixel index selector.
// No dependencies; imported by the top level and by its port checker.
package etc1pis_pkg;

    // Field widths
    localparam int HDR_W     = 32;
    localparam int POS_W     = 2;
    localparam int CH_W      = 8;
    localparam int IDX_W     = 32;
    localparam int ERR_W     = 22;
    localparam int SQ_W      = 16;  // square of a byte difference
    localparam int SUM_W     = 18;  // sum of three squares
    localparam int NUM_K     = 4;   // modifier entries per table row
    localparam int NUM_CH    = 3;

    // Stream packing: slave tdata = header, x, y, red, green, blue (lowest first)
    localparam int S_TDATA_W = 64;
    localparam int S_X_LSB   = 32;
    localparam int S_Y_LSB   = 34;
    localparam int S_R_LSB   = 36;
    localparam int S_G_LSB   = 44;
    localparam int S_B_LSB   = 52;

    // Master tdata = index_bits, total_error (lowest first)
    localparam int M_TDATA_W = 56;
    localparam int M_ERR_LSB = 32;

    // Header bit positions
    localparam int HDR_FLIP    = 24;
    localparam int HDR_DIFF    = 25;
    localparam int HDR_ROW2_LSB = 26;
    localparam int HDR_ROW1_LSB = 29;

    // Index bit 1 sits this far above index bit 0
    localparam int IDX_HI_OFS = 16;

    typedef logic signed [9:0]  t_base;   // decoded base channel, may leave 0..255
    typedef logic signed [8:0]  t_mod;    // modifier value
    typedef logic signed [10:0] t_sum;    // base plus modifier, before clamping

    // Modifier magnitudes per table row: small, large
    localparam logic [7:0] MOD_MAG [8][2] = '{
        '{8'd2,  8'd8},
        '{8'd5,  8'd17},
        '{8'd9,  8'd29},
        '{8'd13, 8'd42},
        '{8'd18, 8'd60},
        '{8'd24, 8'd80},
        '{8'd33, 8'd106},
        '{8'd47, 8'd183}
    };

    // Entries 0,1 positive small/large; entries 2,3 the same negated
    function automatic t_mod modifier(input logic [2:0] row, input logic [1:0] k);
        logic [8:0] mag;
        mag = {1'b0, MOD_MAG[row][k[0]]};
        return k[1] ? t_mod'(-$signed(mag)) : t_mod'($signed(mag));
    endfunction

    // Differential delta times eight: the 3-bit two's complement field shifted up
    function automatic logic signed [5:0] delta_x8(input logic [2:0] d);
        return $signed({d, 3'b000});
    endfunction

    // Base channel of one header byte for subblock sub (0 = first, 1 = second)
    function automatic t_base base_channel(input logic [7:0] b, input logic diff,
                                           input logic sub);
        logic [3:0] nib;
        t_base      v;
        nib = sub ? b[3:0] : b[7:4];
        v   = $signed({2'b00, b[7:3], 3'b000});
        if (sub)
            v = v + t_base'(delta_x8(b[2:0]));
        if (!diff)
            return $signed({2'b00, nib, nib});
        // replicate bits 7..5 (two's complement, no range check) into 2..0
        return v + $signed({7'b0, v[7:5]});
    endfunction

endpackage

// ===== rtl/etc1_pixel_index_selector_top.sv =====
// ETC1 pixel index selector: per-pixel modifier search and block index/error accumulation.
// Depends on etc1pis_pkg for widths, stream offsets and the decode tables.
//
// Usage:
//   Slave stream: one pixel per transfer. tdata carries (lowest bit first) the
//   32-bit block header, pixel x (2), pixel y (2), red, green, blue (8 each);
//   tlast marks the last pixel of a block.
//   Master stream: one transfer per block, tdata = index word (32) then total
//   squared error (22).
//   Pipeline: input register, squared-error register, result register. A pixel
//   is accepted every cycle while not stalled; a block's last pixel passes the input
//   and squared-error registers, then m_axis_tvalid rises as it loads the result.
//   The index and error accumulators are updated as a pixel leaves the second
//   stage and clear when a block result is loaded.
//   Stall: a held result blocks only a further last pixel in the second stage;
//   ready drops only while that last pixel waits and the input register is full.
//   Reset (i_rst_n low, synchronous) empties the pipeline and clears both
//   accumulators.
module etc1_pixel_index_selector_top
    import etc1pis_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // header_word[31:0], pixel_x[33:32], pixel_y[35:34], pixel_red[43:36],
    // pixel_green[51:44], pixel_blue[59:52], zero fill[63:60]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,   // last_pixel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // index_bits[31:0], total_error[53:32], zero fill[55:54]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Stage 1: input register
    logic                r_s1_valid;
    logic                r_s1_last;
    logic [HDR_W-1:0]    r_s1_hdr;
    logic [POS_W-1:0]    r_s1_x;
    logic [POS_W-1:0]    r_s1_y;
    logic [CH_W-1:0]     r_s1_px [NUM_CH];

    // Stage 2: squared channel errors
    logic                r_s2_valid;
    logic                r_s2_last;
    logic [2*POS_W-1:0]  r_s2_pos;
    logic [SQ_W-1:0]     r_s2_sq [NUM_K][NUM_CH];
    logic [SQ_W-1:0]     n_s2_sq [NUM_K][NUM_CH];

    // Accumulators and result register
    logic [IDX_W-1:0]    r_idx_acc;
    logic [ERR_W-1:0]    r_err_acc;
    logic [IDX_W-1:0]    n_idx_acc;
    logic [ERR_W-1:0]    n_err_acc;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [ERR_W-1:0]    r_out_err;

    logic                move_s2;
    logic                s2_free;
    logic                move_s1;
    logic                s_xfer;

    // Flow control
    always_comb begin
        move_s2       = r_s2_valid && !(r_s2_last && r_out_valid && !m_axis_tready);
        s2_free       = !r_s2_valid || move_s2;
        move_s1       = r_s1_valid && s2_free;
        s_axis_tready = !r_s1_valid || move_s1;
        s_xfer        = s_axis_tvalid && s_axis_tready;
    end

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (move_s1) begin
            r_s1_valid <= 1'b0;
        end
        if (s_xfer) begin
            r_s1_last  <= s_axis_tlast;
            r_s1_hdr   <= s_axis_tdata[HDR_W-1:0];
            r_s1_x     <= s_axis_tdata[S_X_LSB +: POS_W];
            r_s1_y     <= s_axis_tdata[S_Y_LSB +: POS_W];
            r_s1_px[0] <= s_axis_tdata[S_R_LSB +: CH_W];
            r_s1_px[1] <= s_axis_tdata[S_G_LSB +: CH_W];
            r_s1_px[2] <= s_axis_tdata[S_B_LSB +: CH_W];
        end
    end

    // Header decode, candidate colors, clamp and squared differences
    always_comb begin
        logic               flip;
        logic               diff;
        logic               sub;
        logic [2:0]         row;
        t_base              base [NUM_CH];
        t_sum               cand;
        logic [CH_W-1:0]    clamped;
        logic signed [8:0]  d;
        logic [CH_W-1:0]    mag;
        flip = r_s1_hdr[HDR_FLIP];
        diff = r_s1_hdr[HDR_DIFF];
        sub  = flip ? r_s1_y[1] : r_s1_x[1];
        row  = sub ? r_s1_hdr[HDR_ROW2_LSB +: 3] : r_s1_hdr[HDR_ROW1_LSB +: 3];
        for (int c = 0; c < NUM_CH; c++) begin
            base[c] = base_channel(r_s1_hdr[8*c +: 8], diff, sub);
        end
        for (int k = 0; k < NUM_K; k++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                cand = t_sum'(base[c]) + t_sum'(modifier(row, 2'(k)));
                if (cand < 0)
                    clamped = '0;
                else if (cand > 11'sd255)
                    clamped = '1;
                else
                    clamped = cand[CH_W-1:0];
                d   = $signed({1'b0, clamped}) - $signed({1'b0, r_s1_px[c]});
                mag = d[8] ? CH_W'(-d) : d[CH_W-1:0];
                n_s2_sq[k][c] = SQ_W'(mag) * SQ_W'(mag);
            end
        end
    end

    // Stage 2 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (move_s1) begin
            r_s2_valid <= 1'b1;
        end else if (move_s2) begin
            r_s2_valid <= 1'b0;
        end
        if (move_s1) begin
            r_s2_last <= r_s1_last;
            r_s2_pos  <= {r_s1_x, r_s1_y};   // dy + 4*dx
            r_s2_sq   <= n_s2_sq;
        end
    end

    // Error sums, best index (lowest wins ties), index placement
    always_comb begin
        logic [SUM_W-1:0] e [NUM_K];
        logic             pick_lo;
        logic             pick_hi;
        logic [SUM_W-1:0] e_lo;
        logic [SUM_W-1:0] e_hi;
        logic [1:0]       best;
        logic [SUM_W-1:0] best_e;
        for (int k = 0; k < NUM_K; k++) begin
            e[k] = SUM_W'(r_s2_sq[k][0]) + SUM_W'(r_s2_sq[k][1]) + SUM_W'(r_s2_sq[k][2]);
        end
        pick_lo = e[1] < e[0];
        pick_hi = e[3] < e[2];
        e_lo    = pick_lo ? e[1] : e[0];
        e_hi    = pick_hi ? e[3] : e[2];
        if (e_hi < e_lo) begin
            best   = {1'b1, pick_hi};
            best_e = e_hi;
        end else begin
            best   = {1'b0, pick_lo};
            best_e = e_lo;
        end
        n_idx_acc = r_idx_acc
                  | (IDX_W'(best[0]) << r_s2_pos)
                  | (IDX_W'(best[1]) << (5'(r_s2_pos) + 5'(IDX_HI_OFS)));
        n_err_acc = r_err_acc + ERR_W'(best_e);
    end

    // Accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx_acc <= '0;
            r_err_acc <= '0;
        end else if (move_s2) begin
            if (r_s2_last) begin
                r_idx_acc <= '0;
                r_err_acc <= '0;
            end else begin
                r_idx_acc <= n_idx_acc;
                r_err_acc <= n_err_acc;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move_s2 && r_s2_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (move_s2 && r_s2_last) begin
            r_out_idx <= n_idx_acc;
            r_out_err <= n_err_acc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W-IDX_W-ERR_W)'(0), r_out_err, r_out_idx};

endmodule

// ===== rtl/etc1pis_checker.sv =====
// Port-level checker for the ETC1 pixel index selector, bound to the top level.
// Depends on etc1pis_pkg for the stream widths.
module etc1pis_checker
    import etc1pis_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 s_axis_tlast,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result keeps its value
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the result register
    ap_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Input backpressure only while a result is held by the receiver
    ap_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    // A block result is on the output after its last pixel if none was waiting when that pixel was taken
    ap_last_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid
        |-> ##3 m_axis_tvalid)
        else $error("no result after last pixel");

endmodule

bind etc1_pixel_index_selector_top etc1pis_checker u_etc1pis_checker (.*);

// ===== dv/etc1_pixel_index_selector_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ETC1 pixel index selector: watches both stream channels,
// predicts every block result from the accepted pixels and compares field by field.
// Depends on etc1pis_pkg for stream widths and field offsets.
module etc1_pixel_index_selector_checker
    import etc1pis_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tlast,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_blocks
);

    typedef struct packed {
        logic [IDX_W-1:0] index_bits;
        logic [ERR_W-1:0] total_error;
    } t_block_result;

    // Modifier table rows and differential delta times eight
    localparam int MOD_TAB [8][4] = '{
        '{2, 8, -2, -8},       '{5, 17, -5, -17},
        '{9, 29, -9, -29},     '{13, 42, -13, -42},
        '{18, 60, -18, -60},   '{24, 80, -24, -80},
        '{33, 106, -33, -106}, '{47, 183, -47, -183}
    };
    localparam int DELTA_X8 [8] = '{0, 8, 16, 24, -32, -24, -16, -8};

    t_block_result        block_results_q[$];
    logic [IDX_W-1:0]     idx_word;
    logic [ERR_W-1:0]     err_sum;
    int                   mismatches = 0;
    int                   blocks_seen = 0;

    // Best modifier index of one pixel and its squared RGB error; lowest index wins ties
    function automatic void select_index(input logic [HDR_W-1:0] hdr,
                                         input logic [POS_W-1:0] px, py,
                                         input logic [CH_W-1:0] r, g, b,
                                         output logic [1:0] best_idx,
                                         output int best_err);
        logic       sub;
        logic [2:0] row;
        logic [7:0] hbyte;
        int         base [3];
        int         pix [3];
        int         sum, d, e;
        sub = hdr[HDR_FLIP] ? py[1] : px[1];
        row = sub ? hdr[HDR_ROW2_LSB +: 3] : hdr[HDR_ROW1_LSB +: 3];
        pix = '{int'(r), int'(g), int'(b)};
        best_idx = 2'd0;
        best_err = 0;
        for (int c = 0; c < 3; c++) begin
            hbyte = hdr[8*c +: 8];
            if (!hdr[HDR_DIFF]) begin
                base[c] = sub ? int'({hbyte[3:0], hbyte[3:0]}) : int'({hbyte[7:4], hbyte[7:4]});
            end else begin
                base[c] = int'(hbyte & 8'hF8);
                if (sub)
                    base[c] += DELTA_X8[hbyte[2:0]];
                // bits 7..5 taken as two's complement even when out of range
                base[c] += (base[c] & 224) >> 5;
            end
        end
        for (int k = 0; k < 4; k++) begin
            e = 0;
            for (int c = 0; c < 3; c++) begin
                sum = base[c] + MOD_TAB[row][k];
                if (sum < 0)
                    sum = 0;
                else if (sum > 255)
                    sum = 255;
                d = sum - pix[c];
                e += d * d;
            end
            if (k == 0 || e < best_err) begin
                best_err = e;
                best_idx = 2'(k);
            end
        end
    endfunction

    // Compare block results first, then fold in the accepted pixel
    always @(posedge i_clk) begin : watch_blk
        t_block_result got;
        t_block_result want;
        logic [1:0]    sel;
        int            sel_err;
        logic [3:0]    pos;
        if (!i_rst_n) begin
            idx_word = '0;
            err_sum  = '0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.index_bits  = i_m_tdata[IDX_W-1:0];
                got.total_error = i_m_tdata[M_ERR_LSB +: ERR_W];
                blocks_seen++;
                if (block_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected block result, expected none, actual %h / %0d",
                             $time, got.index_bits, got.total_error);
                end else begin
                    want = block_results_q.pop_front();
                    if (got.index_bits !== want.index_bits) begin
                        mismatches++;
                        $display("%0t: index_bits mismatch, expected %h, actual %h",
                                 $time, want.index_bits, got.index_bits);
                    end
                    if (got.total_error !== want.total_error) begin
                        mismatches++;
                        $display("%0t: total_error mismatch, expected %0d, actual %0d",
                                 $time, want.total_error, got.total_error);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                select_index(i_s_tdata[HDR_W-1:0], i_s_tdata[S_X_LSB +: POS_W],
                             i_s_tdata[S_Y_LSB +: POS_W], i_s_tdata[S_R_LSB +: CH_W],
                             i_s_tdata[S_G_LSB +: CH_W], i_s_tdata[S_B_LSB +: CH_W],
                             sel, sel_err);
                // index position is dy + 4*dx
                pos = {i_s_tdata[S_X_LSB +: POS_W], i_s_tdata[S_Y_LSB +: POS_W]};
                idx_word[pos]              = idx_word[pos] | sel[0];
                idx_word[pos + IDX_HI_OFS] = idx_word[pos + IDX_HI_OFS] | sel[1];
                err_sum = err_sum + sel_err[ERR_W-1:0];
                if (i_s_tlast) begin
                    block_results_q.push_back('{index_bits: idx_word, total_error: err_sum});
                    idx_word = '0;
                    err_sum  = '0;
                end
            end
        end
        o_pending <= block_results_q.size();
        o_errors  <= mismatches;
        o_blocks  <= blocks_seen;
    end

endmodule

// ===== dv/etc1_pixel_index_selector_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the ETC1 pixel index selector: clock, reset, pixel stimulus,
// output back-pressure and the verdict. Depends on etc1pis_pkg and the scoreboard.
module etc1_pixel_index_selector_top_tb;
    import etc1pis_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 500;
    localparam int DRAIN_CYCLES  = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // header, x, y, red, green, blue, zero fill
    logic                 s_axis_tlast;   // last_pixel
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // index_bits, total_error, zero fill

    int errors;
    int pending;
    int blocks;
    int pixels_sent = 0;
    bit quiet       = 1'b0;  // no idling on either side
    bit hold_req    = 1'b0;  // ask the receiver for a long hold-off

    etc1_pixel_index_selector_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    etc1_pixel_index_selector_checker scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_blocks   (blocks)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, or a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 20);
            end
        end
    end

    // Watchdog: cycles without any transfer
    initial begin : watchdog_blk
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending);
                $display("etc1_pixel_index_selector_top_tb NOT OK");
                $finish;
            end
        end
    end

    // One pixel transfer; entered and left just after a falling edge
    task automatic send_pixel(input logic [HDR_W-1:0] hdr, input logic [1:0] px, py,
                              input logic [7:0] r, g, b, input logic last);
        while (!quiet && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, b, g, r, py, px, hdr};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    // Channel value biased toward the clamp edges
    function automatic logic [7:0] rand_channel();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // Full block: all sixteen positions in shuffled order under one header
    task automatic send_full_block();
        logic [HDR_W-1:0] hdr;
        logic [3:0]       order [16];
        logic [3:0]       tmp;
        int               j;
        hdr = $urandom();
        for (int i = 0; i < 16; i++)
            order[i] = 4'(i);
        for (int i = 15; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 16; i++)
            send_pixel(hdr, order[i][3:2], order[i][1:0], rand_channel(), rand_channel(),
                       rand_channel(), i == 15);
    endtask

    // Irregular block: 1 to 20 pixels, random positions, header may change per pixel
    task automatic send_odd_block();
        logic [HDR_W-1:0] hdr;
        int               n;
        hdr = $urandom();
        n   = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                hdr = $urandom();
            send_pixel(hdr, 2'($urandom_range(3)), 2'($urandom_range(3)), rand_channel(),
                       rand_channel(), rand_channel(), i == n - 1);
        end
    endtask

    // Stimulus and verdict
    initial begin : stim_blk
        int blk;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes, one-pixel blocks
        send_pixel(32'h0000_0000, 2'd0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(32'hFFFF_FFFF, 2'd3, 2'd3, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // ties: +2/-2 equidistant, then +2/+8 both clamped; header changes within block
        send_pixel(32'h0088_8888, 2'd0, 2'd0, 8'd136, 8'd136, 8'd136, 1'b0);
        send_pixel(32'h00FF_FFFF, 2'd1, 2'd1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // invalid differential headers: second-subblock base below 0 and above 255
        send_pixel(32'h0204_0404, 2'd2, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(32'h02FB_FBFB, 2'd3, 2'd1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(32'h0304_0404, 2'd0, 2'd3, 8'd40, 8'd40, 8'd40, 1'b1);
        // long block, repeated positions, worst error per pixel: error sum wraps
        for (int i = 0; i < 22; i++)
            send_pixel(32'h0204_0404, 2'(2 + (i % 8) / 4), 2'(i % 4), 8'hFF, 8'hFF, 8'hFF,
                       i == 21);

        // sender pause until every block result is back
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // random blocks, mostly well formed
        blk = 0;
        while (pixels_sent < RANDOM_PIXELS + 29) begin
            if (blk == 8)
                hold_req = 1'b1;
            quiet = (blk >= 12 && blk < 20);
            if (blk == 25) begin
                s_axis_tvalid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            if ($urandom_range(99) < 80)
                send_full_block();
            else
                send_odd_block();
            blk++;
        end
        quiet = 1'b0;

        // drain
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d pixels in %0d checked blocks: ties, clamps, invalid differential",
                 pixels_sent, blocks);
        $display("headers, long and broken blocks, a long output hold-off and drain pauses.");
        if (errors == 0)
            $display("etc1_pixel_index_selector_top_tb OK");
        else
            $display("etc1_pixel_index_selector_top_tb NOT OK");
        $finish;
    end

endmodule
